>>> rtl/afu_pkg.sv
// shared types, constants and the tanh segment table of the activation unit
package afu_pkg;

	localparam int DATA_W     = 16;
	localparam int FRAC_W     = 12;
	localparam int SEG_N      = 32;
	localparam int SEG_IDX_W  = 5;
	localparam int SEG_FRAC_W = FRAC_W + 2 - SEG_IDX_W;
	localparam int TAB_W      = 12;
	localparam int DIFF_W     = 10;
	localparam int ARG_W      = 16;
	localparam int T_W        = 14;

	localparam logic signed [DATA_W-1:0] XC_MAX = 16'sd16384;
	localparam logic signed [DATA_W-1:0] XC_MIN = -16'sd16384;
	localparam logic [FRAC_W:0]          TANH_ONE = 13'd4096;

	localparam logic [25:0] K_CUBIC = 26'd48012366;
	localparam logic [29:0] K_S2P   = 30'd856722024;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic [1:0] {
		ACT_RELU = 2'd0,
		ACT_GELU = 2'd1,
		ACT_TANH = 2'd2,
		ACT_PASS = 2'd3
	} act_mode_t;

	typedef struct packed {
		logic      valid;
		act_mode_t mode;
		data_t     x;
	} beat_t;

	function automatic logic [TAB_W-1:0] tanh_tab(input logic [SEG_IDX_W:0] k);
		logic [TAB_W-1:0] v;
		case (k)
			6'd0:  v = 12'd0;
			6'd1:  v = 12'd509;
			6'd2:  v = 12'd1003;
			6'd3:  v = 12'd1468;
			6'd4:  v = 12'd1893;
			6'd5:  v = 12'd2272;
			6'd6:  v = 12'd2602;
			6'd7:  v = 12'd2883;
			6'd8:  v = 12'd3119;
			6'd9:  v = 12'd3315;
			6'd10: v = 12'd3475;
			6'd11: v = 12'd3604;
			6'd12: v = 12'd3707;
			6'd13: v = 12'd3790;
			6'd14: v = 12'd3856;
			6'd15: v = 12'd3908;
			6'd16: v = 12'd3949;
			6'd17: v = 12'd3981;
			6'd18: v = 12'd4006;
			6'd19: v = 12'd4026;
			6'd20: v = 12'd4041;
			6'd21: v = 12'd4053;
			6'd22: v = 12'd4063;
			6'd23: v = 12'd4070;
			6'd24: v = 12'd4076;
			6'd25: v = 12'd4080;
			6'd26: v = 12'd4084;
			6'd27: v = 12'd4086;
			6'd28: v = 12'd4089;
			6'd29: v = 12'd4090;
			6'd30: v = 12'd4091;
			6'd31: v = 12'd4092;
			6'd32: v = 12'd4093;
			default: v = 12'd4093;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/afu_arg.sv
// gelu argument pipeline: clamp, square, cube, cubic term, scale by sqrt(2/pi); tanh beats pass x unscaled
module afu_arg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  afu_pkg::data_t                    x_in,
	input  afu_pkg::act_mode_t                mode,
	output afu_pkg::beat_t                    beat_s4,
	output logic signed [afu_pkg::ARG_W-1:0]  arg_s4
);

	afu_pkg::data_t     xc_in;
	logic signed [31:0] x2_full;
	logic signed [33:0] x3_full;
	logic signed [46:0] cub_full;
	logic signed [16:0] inner;
	logic signed [47:0] arg_full;

	afu_pkg::beat_t     beat_s1, beat_s2, beat_s3;
	afu_pkg::data_t     xc_s1, xc_s2, xc_s3;
	logic signed [17:0] x2_s1;
	logic signed [19:0] x3_s2;
	logic signed [15:0] cub_s3;

	always_comb begin
		if (x_in > afu_pkg::XC_MAX) begin
			xc_in = afu_pkg::XC_MAX;
		end else if (x_in < afu_pkg::XC_MIN) begin
			xc_in = afu_pkg::XC_MIN;
		end else begin
			xc_in = x_in;
		end
	end

	assign x2_full  = xc_in * xc_in;
	assign x3_full  = x2_s1 * xc_s1;
	assign cub_full = x3_s2 * $signed({1'b0, afu_pkg::K_CUBIC});
	assign inner    = {xc_s3[15], xc_s3} + {cub_s3[15], cub_s3};
	assign arg_full = inner * $signed({1'b0, afu_pkg::K_S2P});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s1 <= '0;
			beat_s2 <= '0;
			beat_s3 <= '0;
			beat_s4 <= '0;
		end else begin
			beat_s1 <= '{valid: start, mode: mode, x: x_in};
			beat_s2 <= beat_s1;
			beat_s3 <= beat_s2;
			beat_s4 <= beat_s3;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		xc_s1        <= xc_in;
		x2_s1        <= x2_full[29:12];

		xc_s2        <= xc_s1;
		x3_s2        <= x3_full[31:12];

		xc_s3        <= xc_s2;
		cub_s3       <= cub_full[45:30];

		if (beat_s3.mode == afu_pkg::ACT_TANH) begin
			arg_s4 <= beat_s3.x;
		end else begin
			arg_s4 <= arg_full[45:30];
		end
	end

endmodule

>>> rtl/afu_tanh.sv
// piecewise-linear tanh over [0,4) with odd symmetry and saturation, two stages
module afu_tanh (
	input  logic                             clk,
	input  logic                             arst_n,
	input  afu_pkg::beat_t                   beat_in,
	input  logic signed [afu_pkg::ARG_W-1:0] arg,
	output afu_pkg::beat_t                   beat_s6,
	output logic signed [afu_pkg::T_W-1:0]   t_s6
);

	localparam int DIFF_W_T = afu_pkg::DIFF_W;

	logic signed [afu_pkg::ARG_W:0]      arg_ext;
	logic [afu_pkg::ARG_W:0]             mag;
	logic [afu_pkg::SEG_IDX_W-1:0]       idx;
	logic [afu_pkg::TAB_W-1:0]           lo_val, hi_val;
	logic [afu_pkg::DIFF_W+afu_pkg::SEG_FRAC_W-1:0] prod;
	logic [afu_pkg::FRAC_W:0]            ymag;

	afu_pkg::beat_t                      beat_s5;
	logic [afu_pkg::TAB_W-1:0]           base_s5;
	logic [afu_pkg::DIFF_W-1:0]          diff_s5;
	logic [afu_pkg::SEG_FRAC_W-1:0]      frac_s5;
	logic                                sat_s5;
	logic                                neg_s5;

	assign arg_ext = {arg[afu_pkg::ARG_W-1], arg};
	assign mag     = arg_ext[afu_pkg::ARG_W] ? $unsigned(-arg_ext) : $unsigned(arg_ext);
	assign idx     = mag[afu_pkg::FRAC_W+1:afu_pkg::SEG_FRAC_W];
	assign lo_val  = afu_pkg::tanh_tab({1'b0, idx});
	assign hi_val  = afu_pkg::tanh_tab({1'b0, idx} + 6'd1);

	assign prod = diff_s5 * frac_s5;

	always_comb begin
		if (sat_s5) begin
			ymag = afu_pkg::TANH_ONE;
		end else begin
			ymag = {1'b0, base_s5} + {3'b000, prod[afu_pkg::DIFF_W+afu_pkg::SEG_FRAC_W-1:
				afu_pkg::SEG_FRAC_W]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s5 <= '0;
			beat_s6 <= '0;
		end else begin
			beat_s5 <= beat_in;
			beat_s6 <= beat_s5;
		end
	end

	always_ff @(posedge clk) begin
		base_s5      <= lo_val;
		diff_s5      <= DIFF_W_T'(hi_val - lo_val);
		frac_s5      <= mag[afu_pkg::SEG_FRAC_W-1:0];
		sat_s5       <= |mag[afu_pkg::ARG_W:afu_pkg::FRAC_W+2];
		neg_s5       <= arg[afu_pkg::ARG_W-1];

		if (neg_s5) begin
			t_s6 <= -$signed({1'b0, ymag});
		end else begin
			t_s6 <= $signed({1'b0, ymag});
		end
	end

endmodule

>>> rtl/activation_function_unit.sv
// activation function unit top level: relu, gelu (tanh form), tanh, pass-through
// a beat taken with start passes stages s1 to s6 and the output register, then returns on y_out with done
// throughput: one beat per cycle; busy stays low, the seven-stage pipeline never stalls
// the receiver cannot stall; every beat in flight leaves on its own done cycle
// reset clears all pipeline valid bits and sets act_mode to relu
module activation_function_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [afu_pkg::DATA_W-1:0]   x_in,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_wdata,
	output logic                                done,
	output logic signed [afu_pkg::DATA_W-1:0]   y_out
);

	afu_pkg::act_mode_t                   act_mode_q;
	afu_pkg::beat_t                       beat_s4, beat_s6;
	logic signed [afu_pkg::ARG_W-1:0]     arg_s4;
	logic signed [afu_pkg::T_W-1:0]       t_s6;
	logic signed [afu_pkg::T_W:0]         gain;
	logic signed [30:0]                   gelu_full;
	logic signed [17:0]                   gelu_q;
	afu_pkg::data_t                       gelu_sat;
	afu_pkg::data_t                       y_next;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_mode_q <= afu_pkg::ACT_RELU;
		end else if (cfg_we) begin
			act_mode_q <= afu_pkg::act_mode_t'(cfg_wdata);
		end
	end

	afu_arg u_arg (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.x_in    (x_in),
		.mode    (act_mode_q),
		.beat_s4 (beat_s4),
		.arg_s4  (arg_s4)
	);

	afu_tanh u_tanh (
		.clk     (clk),
		.arst_n  (arst_n),
		.beat_in (beat_s4),
		.arg     (arg_s4),
		.beat_s6 (beat_s6),
		.t_s6    (t_s6)
	);

	// 0.5 * x * (1 + t)
	assign gain      = {t_s6[afu_pkg::T_W-1], t_s6} + 15'sd4096;
	assign gelu_full = beat_s6.x * gain;
	assign gelu_q    = gelu_full[30:13];

	always_comb begin
		if (gelu_q > 18'sd32767) begin
			gelu_sat = 16'sh7fff;
		end else if (gelu_q < -18'sd32768) begin
			gelu_sat = 16'sh8000;
		end else begin
			gelu_sat = gelu_q[15:0];
		end
	end

	always_comb begin
		case (beat_s6.mode)
			afu_pkg::ACT_RELU: y_next = beat_s6.x[afu_pkg::DATA_W-1] ? '0 : beat_s6.x;
			afu_pkg::ACT_GELU: y_next = gelu_sat;
			afu_pkg::ACT_TANH: y_next = {{(afu_pkg::DATA_W-afu_pkg::T_W){t_s6[afu_pkg::T_W-1]}},
				t_s6};
			afu_pkg::ACT_PASS: y_next = beat_s6.x;
			default:           y_next = beat_s6.x;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= beat_s6.valid;
		end
	end

	always_ff @(posedge clk) begin
		y_out <= y_next;
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> ##6 done)
		else $error("beat did not come out after seven cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 7))
		else $error("done without a matching start");

	a_tanh_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(beat_s6.mode == afu_pkg::ACT_TANH) |->
			(y_out <= 16'sd4096) && (y_out >= -16'sd4096))
		else $error("tanh result beyond one");

	a_relu_sign: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(beat_s6.mode == afu_pkg::ACT_RELU) |-> !y_out[afu_pkg::DATA_W-1])
		else $error("relu result negative");

endmodule
